// ----- hw/rtl/wasl_pkg.sv -----
// Shared types, widths and command codes for the weighted action selector.
package wasl_pkg;

  localparam int DEF_MAX_STATES  = 64;
  localparam int DEF_MAX_ACTIONS = 16;

  localparam int KIND_W   = 2;
  localparam int STATE_W  = 6;
  localparam int ACTION_W = 4;
  localparam int AMT_W    = 24;
  localparam int DRAW_W   = 16;
  localparam int NS_REG_W = 7;
  localparam int NA_REG_W = 5;
  localparam int CFG_W    = 7;

  localparam int Q_FRAC = 16;           // fraction bits of a weight
  localparam int W_W    = 17;           // stored weight, Q1.16
  localparam int NV_W   = 25;           // reinforced weight before renormalizing
  localparam int PROD_W = W_W + 1 + AMT_W;

  localparam int RESET_ACTIONS = 16;    // num_actions after reset

  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SCALE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LINEAR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RESET  = 2'd3;

  localparam logic CFG_NUM_STATES  = 1'b0;
  localparam logic CFG_NUM_ACTIONS = 1'b1;

endpackage

// ----- hw/rtl/wasl_weight_ram.sv -----
// Weight table memory: one write port, one registered read port.
module wasl_weight_ram import wasl_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  logic [W_W-1:0] wr_data,
  input  logic [AW-1:0]  rd_addr,
  output logic [W_W-1:0] rd_data
);

  logic [W_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hw/rtl/wasl_div.sv -----
// Bit-serial divider for num * 2^16 / den, num not above den.
module wasl_div import wasl_pkg::*; #(
  parameter int W = 30
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   num,
  input  logic [W-1:0]   den,
  output logic           done,
  output logic [W_W-1:0] quo
);

  localparam int CNT_W = $clog2(Q_FRAC + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     rem;
  logic [W-1:0]     den_r;
  logic [W:0]       rem2;
  logic [W:0]       diff;
  logic             ge;

  assign rem2 = {rem, 1'b0};
  assign diff = rem2 - {1'b0, den_r};
  assign ge   = rem2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(1));
      if (start) begin
        den_r <= den;
        busy  <= 1'b1;
        cnt   <= CNT_W'(Q_FRAC);
        // integer bit first: set only when num equals den
        if (num >= den) begin
          rem <= num - den;
          quo <= W_W'(1);
        end else begin
          rem <= num;
          quo <= '0;
        end
      end else if (busy) begin
        rem <= ge ? diff[W-1:0] : rem2[W-1:0];
        quo <= {quo[W_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/weighted_action_selector_learner_core.sv -----
// Weighted action selector: weight table, sequencer and renormalization.
//
// Requests enter on in_valid/in_stall with kind, state_index, action_index,
// amount and random_draw; each request gives exactly one result on
// out_valid/out_stall (chosen_action, row_was_empty). One request is worked
// on at a time; in_stall is low only while the sequencer waits for work.
// The result sits in an output register, so the next request may enter
// while an earlier result is still stalled.
// Reinforcement time is set by the bit-serial divider and the single memory
// read port; a reset command refills the whole table, one table entry a cycle.
// After rst the table is filled with the uniform weight for 16 actions,
// one entry a cycle; no request is taken until that fill is done, but
// configuration writes are taken at any time.
// cfg_ready is always high; write num_states/num_actions only while idle.
module weighted_action_selector_learner_core import wasl_pkg::*; #(
  parameter int MAX_STATES  = DEF_MAX_STATES,
  parameter int MAX_ACTIONS = DEF_MAX_ACTIONS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KIND_W-1:0]   kind,
  input  logic [STATE_W-1:0]  state_index,
  input  logic [ACTION_W-1:0] action_index,
  input  logic signed [AMT_W-1:0] amount,
  input  logic [DRAW_W-1:0]   random_draw,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ACTION_W-1:0] chosen_action,
  output logic                row_was_empty,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  localparam int DEPTH = MAX_STATES * MAX_ACTIONS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int CW    = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
  localparam int NSW   = $clog2(MAX_STATES + 1);
  localparam int NAW   = $clog2(MAX_ACTIONS + 1);
  localparam int SUM_W = 25 + $clog2(MAX_ACTIONS + 1);
  localparam int RESET_N = (MAX_ACTIONS < RESET_ACTIONS) ? MAX_ACTIONS : RESET_ACTIONS;
  localparam logic [W_W-1:0] RESET_FILL = W_W'((1 << Q_FRAC) / RESET_N);

  typedef enum logic [3:0] {
    IDLE, Q_RD, Q_USE, A_RD, A_USE, A_NV, S_RD, S_USE,
    N_RD, N_USE, N_DIV, U_DIV, FILL_ALL, FILL_ROW, FINISH
  } state_t;

  state_t state;

  logic [NS_REG_W-1:0] num_states;
  logic [NA_REG_W-1:0] num_actions;
  logic [NSW-1:0]      ns_eff;
  logic [NAW-1:0]      na_eff;

  logic [KIND_W-1:0]   kind_r;
  logic [RW-1:0]       row;
  logic [ACTION_W-1:0] act_r;
  logic signed [AMT_W-1:0] amt_r;
  logic [DRAW_W-1:0]   draw_r;
  logic [CW-1:0]       col;
  logic [AW-1:0]       fa;
  logic [SUM_W-1:0]    acc;
  logic signed [PROD_W-1:0] prod;
  logic [NV_W-1:0]     nv;
  logic [W_W-1:0]      fill_val;
  logic                init_fill;
  logic [ACTION_W-1:0] res_action;
  logic                res_empty;

  logic                accept;
  logic                st_ok;
  logic                act_ok;
  logic                col_last;
  logic                col_is_act;
  logic [SUM_W-1:0]    x;
  logic [SUM_W-1:0]    acc_n;
  logic [AW-1:0]       row_addr;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [W_W-1:0]      wr_data;
  logic [W_W-1:0]      rd_data;

  logic                div_start;
  logic [SUM_W-1:0]    div_num;
  logic [SUM_W-1:0]    div_den;
  logic                div_done;
  logic [W_W-1:0]      div_q;

  // clamp registers to the sizes in use
  always_comb begin
    if (num_states == '0) begin
      ns_eff = NSW'(1);
    end else if (32'(num_states) > MAX_STATES) begin
      ns_eff = NSW'(MAX_STATES);
    end else begin
      ns_eff = NSW'(num_states);
    end
    if (num_actions == '0) begin
      na_eff = NAW'(1);
    end else if (32'(num_actions) > MAX_ACTIONS) begin
      na_eff = NAW'(MAX_ACTIONS);
    end else begin
      na_eff = NAW'(num_actions);
    end
  end

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state != IDLE);
  assign cfg_ready  = 1'b1;
  assign st_ok      = 32'(state_index) < 32'(ns_eff);
  assign act_ok     = 32'(action_index) < 32'(na_eff);
  assign col_last   = 32'(col) == (32'(na_eff) - 32'd1);
  assign col_is_act = (32'(col) == 32'(act_r)) && (kind_r != KIND_QUERY);
  assign x          = col_is_act ? SUM_W'(nv) : SUM_W'(rd_data);
  assign acc_n      = acc + x;
  assign row_addr   = AW'(AW'(row) * AW'(MAX_ACTIONS) + AW'(col));

  assign wr_en   = (state == FILL_ALL) || (state == FILL_ROW) || (state == N_DIV && div_done);
  assign wr_addr = (state == FILL_ALL) ? fa : row_addr;
  assign wr_data = (state == N_DIV) ? div_q : fill_val;

  // uniform weight is 1 * 2^16 / n; renormalization is x * 2^16 / sum
  assign div_start = (accept && kind == KIND_RESET)
                  || (state == S_USE && col_last && acc_n == '0)
                  || (state == N_USE);
  assign div_num   = (state == N_USE) ? x : SUM_W'(1);
  assign div_den   = (state == N_USE) ? acc : SUM_W'(na_eff);

  wasl_weight_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (row_addr),
    .rd_data (rd_data)
  );

  wasl_div #(.W(SUM_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      num_states  <= NS_REG_W'(64);
      num_actions <= NA_REG_W'(RESET_ACTIONS);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_STATES:  num_states  <= cfg_data[NS_REG_W-1:0];
        CFG_NUM_ACTIONS: num_actions <= cfg_data[NA_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FILL_ALL;
      init_fill <= 1'b1;
      fill_val  <= RESET_FILL;
      fa        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            kind_r     <= kind;
            row        <= RW'(state_index);
            act_r      <= action_index;
            amt_r      <= amount;
            draw_r     <= random_draw;
            acc        <= '0;
            res_action <= '0;
            res_empty  <= 1'b0;
            if (kind == KIND_RESET) begin
              state <= U_DIV;
            end else if (!st_ok) begin
              state <= FINISH;
            end else if (kind == KIND_QUERY) begin
              col   <= '0;
              state <= Q_RD;
            end else if (!act_ok) begin
              state <= FINISH;
            end else begin
              col   <= CW'(action_index);
              state <= A_RD;
            end
          end
        end
        Q_RD: state <= Q_USE;
        Q_USE: begin
          acc <= acc_n;
          // first hit wins; on the last action the pick is that action anyway
          if (SUM_W'(draw_r) <= acc_n || col_last) begin
            res_action <= ACTION_W'(col);
            state      <= FINISH;
          end else begin
            col   <= col + 1'b1;
            state <= Q_RD;
          end
        end
        A_RD: state <= A_USE;
        A_USE: begin
          if (kind_r == KIND_SCALE) begin
            prod <= $signed({1'b0, rd_data}) * amt_r;
          end else begin
            prod <= PROD_W'($signed({1'b0, rd_data})) + PROD_W'(amt_r);
          end
          state <= A_NV;
        end
        A_NV: begin
          if (prod[PROD_W-1]) begin
            nv <= '0;
          end else if (kind_r == KIND_SCALE) begin
            nv <= prod[Q_FRAC +: NV_W];
          end else begin
            nv <= prod[NV_W-1:0];
          end
          col   <= '0;
          state <= S_RD;
        end
        S_RD: state <= S_USE;
        S_USE: begin
          acc <= acc_n;
          if (col_last) begin
            col <= '0;
            if (acc_n == '0) begin
              state <= U_DIV;
            end else begin
              state <= N_RD;
            end
          end else begin
            col   <= col + 1'b1;
            state <= S_RD;
          end
        end
        N_RD: state <= N_USE;
        N_USE: state <= N_DIV;
        N_DIV: begin
          if (div_done) begin
            if (col_last) begin
              state <= FINISH;
            end else begin
              col   <= col + 1'b1;
              state <= N_RD;
            end
          end
        end
        U_DIV: begin
          if (div_done) begin
            fill_val <= div_q;
            fa       <= '0;
            col      <= '0;
            state    <= (kind_r == KIND_RESET) ? FILL_ALL : FILL_ROW;
          end
        end
        FILL_ALL: begin
          fa <= fa + 1'b1;
          if (fa == AW'(DEPTH - 1)) begin
            init_fill <= 1'b0;
            state     <= init_fill ? IDLE : FINISH;
          end
        end
        FILL_ROW: begin
          col <= col + 1'b1;
          if (32'(col) == MAX_ACTIONS - 1) begin
            res_empty <= 1'b1;
            state     <= FINISH;
          end
        end
        FINISH: begin
          // hold while the previous result is still stalled
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            chosen_action <= res_action;
            row_was_empty <= res_empty;
            state         <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == N_DIV || state == U_DIV))
    else $error("divider finished with no state waiting for it");

  a_query_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == Q_RD || state == Q_USE) |-> !wr_en)
    else $error("table written during a query");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |=> !div_done)
    else $error("divider reported done right after start");

endmodule

// ----- bench/tb_weighted_action_selector_learner_core.sv -----
// Self-checking bench for the weighted action selector: directed rows, then random phases.
module tb_weighted_action_selector_learner_core;
  import wasl_pkg::*;

  localparam int ROWS = DEF_MAX_STATES;
  localparam int COLS = DEF_MAX_ACTIONS;
  localparam int RANDOM_PER_PHASE = 235;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [KIND_W-1:0]          kind = KIND_QUERY;
  logic [STATE_W-1:0]         state_index = '0;
  logic [ACTION_W-1:0]        action_index = '0;
  logic signed [AMT_W-1:0]    amount = '0;
  logic [DRAW_W-1:0]          random_draw = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [ACTION_W-1:0]        chosen_action;
  logic                       row_was_empty;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic                       cfg_index = CFG_NUM_STATES;
  logic [CFG_W-1:0]           cfg_data = '0;

  typedef struct {
    logic [KIND_W-1:0]       k;
    logic [STATE_W-1:0]      st;
    logic [ACTION_W-1:0]     act;
    logic signed [AMT_W-1:0] amt;
    logic [DRAW_W-1:0]       draw;
    bit                      typed;
    logic [ACTION_W-1:0]     want_action;
    logic                    want_empty;
  } request_t;

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic                empty;
  } selection_t;

  // model copy of the table and registers
  int unsigned        weights [ROWS][COLS];
  logic [NS_REG_W-1:0] states_reg;
  logic [NA_REG_W-1:0] actions_reg;
  selection_t         pending_selections [$];
  int                 errors = 0;
  int                 burst_left = 0;

  weighted_action_selector_learner_core dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int rows_in_use();
    if (states_reg == 0) return 1;
    if (states_reg > ROWS) return ROWS;
    return states_reg;
  endfunction

  function automatic int cols_in_use();
    if (actions_reg == 0) return 1;
    if (actions_reg > COLS) return COLS;
    return actions_reg;
  endfunction

  function automatic void refill_row(int r);
    for (int c = 0; c < COLS; c++) weights[r][c] = 65536 / cols_in_use();
  endfunction

  function automatic selection_t select_and_learn(request_t rq);
    selection_t res;
    int na;
    longint w, v, total, acc;
    na = cols_in_use();
    res.action = '0;
    res.empty = 1'b0;
    if (rq.k == KIND_RESET) begin
      for (int r = 0; r < ROWS; r++) refill_row(r);
      return res;
    end
    if (rq.st >= rows_in_use()) return res;
    if (rq.k == KIND_QUERY) begin
      acc = 0;
      res.action = ACTION_W'(na - 1);
      for (int c = 0; c < na; c++) begin
        acc += weights[rq.st][c];
        if (rq.draw <= acc) begin
          res.action = ACTION_W'(c);
          break;
        end
      end
      return res;
    end
    if (rq.act >= na) return res;
    w = weights[rq.st][rq.act];
    if (rq.k == KIND_SCALE) begin
      v = w * longint'(rq.amt);
      v = (v < 0) ? 0 : (v >>> 16);
    end else begin
      v = w + longint'(rq.amt);
      if (v < 0) v = 0;
    end
    total = 0;
    for (int c = 0; c < na; c++) total += (c == rq.act) ? v : weights[rq.st][c];
    if (total == 0) begin
      refill_row(rq.st);
      res.empty = 1'b1;
      return res;
    end
    for (int c = 0; c < na; c++) begin
      w = (c == rq.act) ? v : weights[rq.st][c];
      weights[rq.st][c] = int'((w * 65536) / total);
    end
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic send(request_t rq);
    selection_t res;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
    end
    kind <= rq.k;
    state_index <= rq.st;
    action_index <= rq.act;
    amount <= rq.amt;
    random_draw <= rq.draw;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    res = select_and_learn(rq);
    if (rq.typed) begin
      res.action = rq.want_action;
      res.empty = rq.want_empty;
    end
    pending_selections.push_back(res);
    burst_left--;
  endtask

  task automatic write_reg(logic idx, int value);
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == CFG_NUM_STATES) states_reg = NS_REG_W'(value);
    else actions_reg = NA_REG_W'(value);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    wait (pending_selections.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic request_t random_request();
    request_t rq;
    int pick;
    rq.typed = 1'b0;
    rq.want_action = '0;
    rq.want_empty = 1'b0;
    pick = $urandom_range(0, 199);
    rq.k = (pick < 3) ? KIND_RESET : (pick < 95) ? KIND_QUERY :
           (pick < 148) ? KIND_SCALE : KIND_LINEAR;
    rq.st = ($urandom_range(0, 9) == 0) ? STATE_W'($urandom) :
            STATE_W'($urandom_range(0, rows_in_use() - 1));
    rq.act = ($urandom_range(0, 9) == 0) ? ACTION_W'($urandom) :
             ACTION_W'($urandom_range(0, cols_in_use() - 1));
    rq.draw = DRAW_W'($urandom);
    pick = $urandom_range(0, 9);
    if (pick == 0) rq.amt = AMT_W'($urandom);
    else if (rq.k == KIND_SCALE)
      rq.amt = (pick == 1) ? -AMT_W'($urandom_range(0, 65536)) :
               AMT_W'($urandom_range(0, 131072));
    else
      rq.amt = AMT_W'(int'($urandom_range(0, 140000)) - 70000);
    return rq;
  endfunction

  // receiver stall pattern: steps through four modes in turn
  int stall_cycle = 0;
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    case ((stall_cycle / 64) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 0);
      2: out_stall <= ((stall_cycle % 16) < 11);
      default: out_stall <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_selections.size() == 0) begin
        report("unexpected result", chosen_action, 0);
      end else begin
        selection_t want;
        want = pending_selections.pop_front();
        if (chosen_action !== want.action) report("chosen_action", chosen_action, want.action);
        if (row_was_empty !== want.empty) report("row_was_empty", row_was_empty, want.empty);
      end
    end
  end

  request_t directed [] = '{
    '{KIND_QUERY,  0,  0, 0,          0,     1, 0,  0},
    '{KIND_QUERY,  63, 0, 0,          65535, 1, 15, 0},
    '{KIND_QUERY,  9,  0, 0,          4096,  1, 0,  0},
    '{KIND_QUERY,  9,  0, 0,          4097,  1, 1,  0},
    '{KIND_LINEAR, 1,  15, 24'h800000, 0,    1, 0,  0},
    '{KIND_QUERY,  1,  0, 0,          65535, 0, 0,  0},
    '{KIND_SCALE,  2,  0, 24'h7fffff, 0,     1, 0,  0},
    '{KIND_QUERY,  2,  0, 0,          1,     0, 0,  0},
    '{KIND_QUERY,  2,  0, 0,          65535, 0, 0,  0},
    '{KIND_SCALE,  3,  5, 0,          0,     1, 0,  0},
    '{KIND_QUERY,  3,  0, 0,          65535, 0, 0,  0},
    '{KIND_SCALE,  4,  7, 24'hffffff, 0,     1, 0,  0},
    '{KIND_LINEAR, 5,  3, 24'h7fffff, 0,     1, 0,  0},
    '{KIND_QUERY,  5,  0, 0,          32768, 0, 0,  0},
    '{KIND_LINEAR, 6,  8, 24'h010000, 0,     0, 0,  0},
    '{KIND_QUERY,  6,  0, 0,          43690, 0, 0,  0},
    '{KIND_RESET,  0,  0, 0,          0,     1, 0,  0},
    '{KIND_QUERY,  5,  0, 0,          65535, 1, 15, 0},
    '{KIND_QUERY,  2,  0, 0,          8193,  1, 2,  0}
  };

  int phase_states [8]  = '{64, 1, 0, 127, 7, 64, 33, 96};
  int phase_actions [8] = '{16, 1, 0, 31,  3, 2,  16, 17};

  initial begin
    states_reg = 64;
    actions_reg = RESET_ACTIONS;
    for (int r = 0; r < ROWS; r++) refill_row(r);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send(directed[i]);
    drain();
    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_NUM_STATES, phase_states[p]);
      write_reg(CFG_NUM_ACTIONS, phase_actions[p]);
      cfg_valid <= 1'b0;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send(random_request());
      drain();
    end
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_selections.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
